>>> rtl/hfd_pkg.sv
`default_nettype none
package hfd_pkg;

    localparam logic [7:0] START_BYTE   = 8'hA5;
    localparam logic [7:0] DEVMGMT_TOP  = 8'h27;
    localparam logic [7:0] RADIO_TOP    = 8'h05;
    localparam logic [7:0] RLTEST_TOP   = 8'h07;
    localparam logic [7:0] HWTEST_TOP   = 8'h02;

    localparam int TDATA_W = 40;

    typedef enum logic [1:0] {
        CFG_DEVMGMT_EP    = 2'd0,
        CFG_RADIOLINK_EP  = 2'd1,
        CFG_RLTEST_EP     = 2'd2,
        CFG_HWTEST_EP     = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_CTRL    = 3'd1,
        PH_MSGID   = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_TRAILER = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        K_PAYLOAD      = 3'd0,
        K_FRAME_DONE   = 3'd1,
        K_BAD_START    = 3'd2,
        K_RESERVED_BIT = 3'd3,
        K_BAD_ENDPOINT = 3'd4,
        K_BAD_MSGID    = 3'd5
    } kind_t;

    // flags: bit0 timestamp, bit1 rssi, bit2 crc
    typedef struct packed {
        kind_t       kind;
        logic [3:0]  endpoint;
        logic [7:0]  msg_id;
        logic [7:0]  payload_length;
        logic [7:0]  data_byte;
        logic [7:0]  byte_index;
        logic [2:0]  flags;
        logic        last_of_step;
    } result_t;

    function automatic logic [2:0] trailer_bytes(input logic [2:0] flags);
        logic [2:0] n;
        n = (flags[0] ? 3'd4 : 3'd0) + (flags[1] ? 3'd1 : 3'd0) + (flags[2] ? 3'd2 : 3'd0);
        return n;
    endfunction

endpackage
`default_nettype wire

>>> rtl/hci_frame_deframer_unit.sv
// timing: an accepted byte's first result is on the master side in the next cycle
// throughput: one byte per cycle while results drain; a payload's last byte with no
//   trailer yields two results, stalling the slave side till the second has the port
// reset (aresetn low, synchronous): parser hunts for the start byte, frame fields
//   clear, endpoint registers load 1, 2, 3, 4, output slots empty
`default_nettype none
module hci_frame_deframer_unit
    import hfd_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // configuration write port
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [3:0]          cfg_wdata,
    // received bytes
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [7:0]          s_tdata,   // [7:0] rx_byte
    // results
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // [3:0] endpoint, [11:4] msg_id, [19:12] payload_length, [27:20] data_byte,
    // [35:28] byte_index, [36] ts_flag, [37] rssi_flag, [38] crc_flag, [39] zero
    output logic [TDATA_W-1:0]       m_tdata,
    output logic [2:0]               m_tuser,   // [2:0] kind
    output logic                     m_tlast    // last_of_step
);

    // endpoint configuration
    logic [3:0] devmgmt_ep_reg, radiolink_ep_reg, rltest_ep_reg, hwtest_ep_reg;

    // parser state
    phase_t     phase_reg, phase_next;
    logic [3:0] ep_reg, ep_next;
    logic [7:0] msgid_reg, msgid_next;
    logic [2:0] flags_reg, flags_next;
    logic [7:0] len_reg, len_next;
    logic [8:0] count_reg, count_next;

    // two-deep result buffer: slot a drives the port, slot b holds a second result
    logic    a_valid_reg, a_valid_next;
    logic    b_valid_reg, b_valid_next;
    result_t a_reg, a_next;
    result_t b_reg, b_next;

    // results of the byte being accepted
    result_t r0, r1;
    logic [1:0] n_res;

    logic s_accept;
    assign s_tready = !b_valid_reg && (!a_valid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;

    // config writes; write only when idle, the block itself does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            devmgmt_ep_reg   <= 4'd1;
            radiolink_ep_reg <= 4'd2;
            rltest_ep_reg    <= 4'd3;
            hwtest_ep_reg    <= 4'd4;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_DEVMGMT_EP:   devmgmt_ep_reg   <= cfg_wdata;
                CFG_RADIOLINK_EP: radiolink_ep_reg <= cfg_wdata;
                CFG_RLTEST_EP:    rltest_ep_reg    <= cfg_wdata;
                CFG_HWTEST_EP:    hwtest_ep_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // per-byte parse
    logic [7:0] b;
    logic       ep_known, id_bad;
    logic [7:0] idx;
    logic [8:0] idx_inc;
    logic       last_payload, no_trailer;
    logic [8:0] count_inc;
    assign b = s_tdata;

    always_comb begin
        ep_known = (b[3:0] == devmgmt_ep_reg) || (b[3:0] == radiolink_ep_reg)
                || (b[3:0] == rltest_ep_reg) || (b[3:0] == hwtest_ep_reg);
        // every matching register must accept the id
        id_bad = ((devmgmt_ep_reg == ep_reg) && (b == 8'd0 || b > DEVMGMT_TOP))
              || ((radiolink_ep_reg == ep_reg) && (b == 8'd0 || b > RADIO_TOP))
              || ((rltest_ep_reg == ep_reg) && (b == 8'd0 || b > RLTEST_TOP))
              || ((hwtest_ep_reg == ep_reg) && (b == 8'd0 || b > HWTEST_TOP));
        idx          = count_reg[7:0];
        idx_inc      = {1'b0, idx} + 9'd1;
        last_payload = idx_inc >= {1'b0, len_reg};
        no_trailer   = trailer_bytes(flags_reg) == 3'd0;
        count_inc    = count_reg + 9'd1;
    end

    always_comb begin
        phase_next = phase_reg;
        ep_next    = ep_reg;
        msgid_next = msgid_reg;
        flags_next = flags_reg;
        len_next   = len_reg;
        count_next = count_reg;
        n_res      = 2'd0;
        r0         = '0;
        r1         = '0;
        r0.last_of_step = 1'b1;
        r1.last_of_step = 1'b1;

        case (phase_reg)
            PH_CTRL: begin
                if (b[4]) begin
                    // reserved bit wins over the endpoint check
                    r0.kind     = K_RESERVED_BIT;
                    r0.endpoint = b[3:0];
                    r0.flags    = b[7:5];
                    n_res       = 2'd1;
                    phase_next  = PH_HUNT;
                    count_next  = '0;
                end else if (!ep_known) begin
                    r0.kind     = K_BAD_ENDPOINT;
                    r0.endpoint = b[3:0];
                    r0.flags    = b[7:5];
                    n_res       = 2'd1;
                    phase_next  = PH_HUNT;
                    count_next  = '0;
                end else begin
                    ep_next    = b[3:0];
                    flags_next = b[7:5];
                    phase_next = PH_MSGID;
                end
            end
            PH_MSGID: begin
                if (id_bad) begin
                    r0.kind     = K_BAD_MSGID;
                    r0.endpoint = ep_reg;
                    r0.msg_id   = b;
                    r0.flags    = flags_reg;
                    n_res       = 2'd1;
                    phase_next  = PH_HUNT;
                    count_next  = '0;
                end else begin
                    msgid_next = b;
                    phase_next = PH_LEN;
                end
            end
            PH_LEN: begin
                len_next   = b;
                count_next = '0;
                if (b != 8'd0) begin
                    phase_next = PH_PAYLOAD;
                end else if (!no_trailer) begin
                    phase_next = PH_TRAILER;
                end else begin
                    // empty frame with no trailer ends here
                    r0.kind     = K_FRAME_DONE;
                    r0.endpoint = ep_reg;
                    r0.msg_id   = msgid_reg;
                    r0.flags    = flags_reg;
                    n_res       = 2'd1;
                    phase_next  = PH_HUNT;
                end
            end
            PH_PAYLOAD: begin
                r0.kind           = K_PAYLOAD;
                r0.endpoint       = ep_reg;
                r0.msg_id         = msgid_reg;
                r0.payload_length = len_reg;
                r0.data_byte      = b;
                r0.byte_index     = idx;
                r0.flags          = flags_reg;
                r0.last_of_step   = !(last_payload && no_trailer);
                n_res             = 2'd1;
                if (!last_payload) begin
                    count_next = count_inc;
                end else begin
                    count_next = '0;
                    if (!no_trailer) begin
                        phase_next = PH_TRAILER;
                    end else begin
                        // payload byte followed by frame done
                        r1.kind           = K_FRAME_DONE;
                        r1.endpoint       = ep_reg;
                        r1.msg_id         = msgid_reg;
                        r1.payload_length = len_reg;
                        r1.flags          = flags_reg;
                        n_res             = 2'd2;
                        phase_next        = PH_HUNT;
                    end
                end
            end
            PH_TRAILER: begin
                count_next = count_inc;
                if (count_inc >= {6'd0, trailer_bytes(flags_reg)}) begin
                    r0.kind           = K_FRAME_DONE;
                    r0.endpoint       = ep_reg;
                    r0.msg_id         = msgid_reg;
                    r0.payload_length = len_reg;
                    r0.flags          = flags_reg;
                    n_res             = 2'd1;
                    phase_next        = PH_HUNT;
                    count_next        = '0;
                end
            end
            default: begin
                // hunting, also covers unused phase codes
                if (b == START_BYTE) begin
                    ep_next    = '0;
                    msgid_next = '0;
                    flags_next = '0;
                    len_next   = '0;
                    count_next = '0;
                    phase_next = PH_CTRL;
                end else begin
                    r0.kind    = K_BAD_START;
                    n_res      = 2'd1;
                    phase_next = PH_HUNT;
                    count_next = '0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            ep_reg    <= '0;
            msgid_reg <= '0;
            flags_reg <= '0;
            len_reg   <= '0;
            count_reg <= '0;
        end else if (s_accept) begin
            phase_reg <= phase_next;
            ep_reg    <= ep_next;
            msgid_reg <= msgid_next;
            flags_reg <= flags_next;
            len_reg   <= len_next;
            count_reg <= count_next;
        end
    end

    // output buffer update
    always_comb begin
        a_valid_next = a_valid_reg;
        b_valid_next = b_valid_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        if (s_accept) begin
            // slot a is free or drains this cycle, slot b is empty
            a_valid_next = n_res != 2'd0;
            b_valid_next = n_res == 2'd2;
            a_next       = r0;
            b_next       = r1;
        end else if (a_valid_reg && m_tready) begin
            a_valid_next = b_valid_reg;
            b_valid_next = 1'b0;
            a_next       = b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign m_tvalid = a_valid_reg;
    assign m_tuser  = a_reg.kind;
    assign m_tlast  = a_reg.last_of_step;
    assign m_tdata  = {1'b0, a_reg.flags[2], a_reg.flags[1], a_reg.flags[0],
                       a_reg.byte_index, a_reg.data_byte, a_reg.payload_length,
                       a_reg.msg_id, a_reg.endpoint};

endmodule
`default_nettype wire
